// ===== rtl/r3tb_pkg.sv =====
// r3tb_pkg: shared constants for the radix-3 twiddle butterfly.
// Default field widths and the fixed-point constants of the rotation by sqrt(3)/2.
// No dependencies.
package r3tb_pkg;

	// default widths of samples and Q2.x twiddles
	localparam int SAMPLE_WIDTH_DEF  = 16;
	localparam int TWIDDLE_WIDTH_DEF = 16;

	// sqrt(3)/2 in Q0.16, rounded half up
	localparam int SQRT3_HALF_Q16 = 56756;
	localparam int ROT_SHIFT      = 16;
	localparam int ROT_HALF       = 32768;

endpackage

// ===== rtl/r3tb_in_if.sv =====
// r3tb_in_if: input channel of the radix-3 butterfly (valid/ready plus one butterfly).
// Depends on r3tb_pkg for default widths.
interface r3tb_in_if
	import r3tb_pkg::*;
#(
	parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
	parameter int TWIDDLE_WIDTH = TWIDDLE_WIDTH_DEF
);
	logic                            valid;
	logic                            ready;
	logic signed [SAMPLE_WIDTH-1:0]  x0_re;
	logic signed [SAMPLE_WIDTH-1:0]  x0_im;
	logic signed [SAMPLE_WIDTH-1:0]  x1_re;
	logic signed [SAMPLE_WIDTH-1:0]  x1_im;
	logic signed [SAMPLE_WIDTH-1:0]  x2_re;
	logic signed [SAMPLE_WIDTH-1:0]  x2_im;
	logic signed [TWIDDLE_WIDTH-1:0] w1_re;
	logic signed [TWIDDLE_WIDTH-1:0] w1_im;
	logic signed [TWIDDLE_WIDTH-1:0] w2_re;
	logic signed [TWIDDLE_WIDTH-1:0] w2_im;
	logic                            last_in;

	modport source (
		output valid, x0_re, x0_im, x1_re, x1_im, x2_re, x2_im,
		output w1_re, w1_im, w2_re, w2_im, last_in,
		input  ready
	);

	modport sink (
		input  valid, x0_re, x0_im, x1_re, x1_im, x2_re, x2_im,
		input  w1_re, w1_im, w2_re, w2_im, last_in,
		output ready
	);
endinterface

// ===== rtl/r3tb_out_if.sv =====
// r3tb_out_if: result channel of the radix-3 butterfly (valid/ready plus X0, X1, X2).
// Depends on r3tb_pkg for the default sample width.
interface r3tb_out_if
	import r3tb_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
	localparam int OW = SAMPLE_WIDTH + 3;

	logic                 valid;
	logic                 ready;
	logic signed [OW-1:0] y0_re;
	logic signed [OW-1:0] y0_im;
	logic signed [OW-1:0] y1_re;
	logic signed [OW-1:0] y1_im;
	logic signed [OW-1:0] y2_re;
	logic signed [OW-1:0] y2_im;
	logic                 last_out;

	modport source (
		output valid, y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, last_out,
		input  ready
	);

	modport sink (
		input  valid, y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, last_out,
		output ready
	);
endinterface

// ===== rtl/r3tb_cmul.sv =====
// r3tb_cmul: two-stage complex multiply of a sample by a Q2.x twiddle, rounded half up.
// Stage 1 registers the four partial products, stage 2 the rounded real and imaginary parts.
// Depends on r3tb_pkg.
module r3tb_cmul
	import r3tb_pkg::*;
#(
	parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
	parameter int TWIDDLE_WIDTH = TWIDDLE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [SAMPLE_WIDTH-1:0]  x_re,
	input  logic signed [SAMPLE_WIDTH-1:0]  x_im,
	input  logic signed [TWIDDLE_WIDTH-1:0] w_re,
	input  logic signed [TWIDDLE_WIDTH-1:0] w_im,
	output logic signed [SAMPLE_WIDTH+2:0]  v_re,
	output logic signed [SAMPLE_WIDTH+2:0]  v_im
);
	localparam int PW   = SAMPLE_WIDTH + TWIDDLE_WIDTH;
	localparam int PSW  = PW + 1;
	localparam int VW   = SAMPLE_WIDTH + 3;
	localparam int FRAC = TWIDDLE_WIDTH - 2;
	localparam logic signed [PSW-1:0] Rnd = PSW'(1) <<< (FRAC - 1);

	logic signed [PW-1:0]  p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [VW-1:0]  v_re_s2, v_im_s2;
	logic signed [PSW-1:0] re_sum, im_sum;

	// form the four exact partial products
	always_ff @(posedge clk) begin
		if (en) begin
			p_rr_s1 <= PW'(x_re) * PW'(w_re);
			p_ii_s1 <= PW'(x_im) * PW'(w_im);
			p_ri_s1 <= PW'(x_re) * PW'(w_im);
			p_ir_s1 <= PW'(x_im) * PW'(w_re);
		end
	end

	// combine, add half an LSB, and drop the fraction bits
	always_comb begin
		re_sum = PSW'(p_rr_s1) - PSW'(p_ii_s1) + Rnd;
		im_sum = PSW'(p_ri_s1) + PSW'(p_ir_s1) + Rnd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_re_s2 <= VW'(re_sum >>> FRAC);
			v_im_s2 <= VW'(im_sum >>> FRAC);
		end
	end

	assign v_re = v_re_s2;
	assign v_im = v_im_s2;

endmodule

// ===== rtl/radix3_twiddle_butterfly.sv =====
// radix3_twiddle_butterfly: top level of the pipelined radix-3 DIT butterfly.
// Depends on r3tb_pkg, r3tb_in_if, r3tb_out_if and r3tb_cmul.
//
// Usage:
//   samples carries one butterfly per transfer: x0, x1, x2 (signed samples),
//   w1, w2 (Q2.x twiddles) and last_in. results carries X0, X1, X2, widened by
//   three bits and saturated, with last_out copied from last_in.
//   One butterfly enters per cycle and one result leaves per cycle unless the receiver stalls.
//   An input transfer reaches results.valid through registered stages for
//   twiddle products, product rounding, sum/difference, the multiply by
//   sqrt(3)/2, then rounding and saturation into the output register.
//   Reset clears every stage's valid bit; data registers are not reset.
//   When the receiver holds results.ready low with a result waiting, the
//   whole pipeline holds; samples.ready follows, so nothing is lost or
//   repeated. Bubbles are not closed up; they move along with the data.
module radix3_twiddle_butterfly
	import r3tb_pkg::*;
#(
	parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
	parameter int TWIDDLE_WIDTH = TWIDDLE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	r3tb_in_if.sink     samples,
	r3tb_out_if.source  results
);
	localparam int SW   = SAMPLE_WIDTH;
	localparam int VW   = SW + 3;
	localparam int SUMW = SW + 4;
	localparam int FW   = SW + 5;
	localparam int OW   = SW + 3;
	localparam int RPW  = SUMW + 18;
	localparam logic signed [RPW-1:0] RotK    = RPW'(SQRT3_HALF_Q16);
	localparam logic signed [RPW-1:0] RotHalf = RPW'(ROT_HALF);
	localparam logic signed [FW-1:0]  OutMax  = {{(FW-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic signed [FW-1:0]  OutMin  = ~OutMax;

	logic advance;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                 last_s1, last_s2, last_s3, last_s4, last_s5;
	logic signed [SW-1:0] x0_re_s1, x0_im_s1, x0_re_s2, x0_im_s2;
	logic signed [SW-1:0] x0_re_s3, x0_im_s3;
	logic signed [VW-1:0] v1_re, v1_im, v2_re, v2_im;

	logic signed [SUMW-1:0] sum_re_s3, sum_im_s3, dif_re_s3, dif_im_s3;
	logic signed [SUMW-1:0] mid_re_s4, mid_im_s4;
	logic signed [FW-1:0]   y0_re_s4, y0_im_s4;
	logic signed [RPW-1:0]  rot_re_s4, rot_im_s4;

	logic signed [RPW-1:0] rot_re_rnd, rot_im_rnd;
	logic signed [FW-1:0]  rot_re, rot_im, mid_re, mid_im;

	logic signed [OW-1:0] y0_re_s5, y0_im_s5, y1_re_s5, y1_im_s5, y2_re_s5, y2_im_s5;

	// clamp a widened result to the output range
	function automatic logic signed [OW-1:0] sat(input logic signed [FW-1:0] v);
		logic signed [FW-1:0] c;
		c = v;
		if (v > OutMax) c = OutMax;
		if (v < OutMin) c = OutMin;
		return OW'(c);
	endfunction

	// advance every stage unless a result waits on a stalled receiver
	assign advance       = !vld_s5 || results.ready;
	assign samples.ready = advance;

	// hold valid bits per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= samples.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stages 1 and 2: twiddle multiplies
	r3tb_cmul #(
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.TWIDDLE_WIDTH (TWIDDLE_WIDTH)
	) u_cmul1 (
		.clk  (clk),
		.en   (advance),
		.x_re (samples.x1_re),
		.x_im (samples.x1_im),
		.w_re (samples.w1_re),
		.w_im (samples.w1_im),
		.v_re (v1_re),
		.v_im (v1_im)
	);

	r3tb_cmul #(
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.TWIDDLE_WIDTH (TWIDDLE_WIDTH)
	) u_cmul2 (
		.clk  (clk),
		.en   (advance),
		.x_re (samples.x2_re),
		.x_im (samples.x2_im),
		.w_re (samples.w2_re),
		.w_im (samples.w2_im),
		.v_re (v2_re),
		.v_im (v2_im)
	);

	// carry x0 and the last flag alongside the multiplies
	always_ff @(posedge clk) begin
		if (advance) begin
			x0_re_s1 <= samples.x0_re;
			x0_im_s1 <= samples.x0_im;
			last_s1  <= samples.last_in;
			x0_re_s2 <= x0_re_s1;
			x0_im_s2 <= x0_im_s1;
			last_s2  <= last_s1;
		end
	end

	// stage 3: sums and differences of the twiddled samples
	always_ff @(posedge clk) begin
		if (advance) begin
			sum_re_s3 <= SUMW'(v1_re) + SUMW'(v2_re);
			sum_im_s3 <= SUMW'(v1_im) + SUMW'(v2_im);
			dif_re_s3 <= SUMW'(v2_re) - SUMW'(v1_re);
			dif_im_s3 <= SUMW'(v2_im) - SUMW'(v1_im);
			x0_re_s3  <= x0_re_s2;
			x0_im_s3  <= x0_im_s2;
			last_s3   <= last_s2;
		end
	end

	// stage 4: multiply differences by sqrt(3)/2, form X0 and the midpoint
	always_ff @(posedge clk) begin
		if (advance) begin
			rot_re_s4 <= RPW'(dif_im_s3) * RotK;
			rot_im_s4 <= RPW'(dif_re_s3) * RotK;
			mid_re_s4 <= SUMW'(x0_re_s3) - (sum_re_s3 >>> 1);
			mid_im_s4 <= SUMW'(x0_im_s3) - (sum_im_s3 >>> 1);
			y0_re_s4  <= FW'(x0_re_s3) + FW'(sum_re_s3);
			y0_im_s4  <= FW'(x0_im_s3) + FW'(sum_im_s3);
			last_s4   <= last_s3;
		end
	end

	// round the rotation terms
	always_comb begin
		rot_re_rnd = rot_re_s4 + RotHalf;
		rot_im_rnd = rot_im_s4 + RotHalf;
		rot_re     = FW'(rot_re_rnd >>> ROT_SHIFT);
		rot_im     = FW'(rot_im_rnd >>> ROT_SHIFT);
		mid_re     = FW'(mid_re_s4);
		mid_im     = FW'(mid_im_s4);
	end

	// stage 5: combine, saturate and hold for the receiver
	always_ff @(posedge clk) begin
		if (advance) begin
			y0_re_s5 <= sat(y0_re_s4);
			y0_im_s5 <= sat(y0_im_s4);
			y1_re_s5 <= sat(mid_re - rot_re);
			y1_im_s5 <= sat(mid_im + rot_im);
			y2_re_s5 <= sat(mid_re + rot_re);
			y2_im_s5 <= sat(mid_im - rot_im);
			last_s5  <= last_s4;
		end
	end

	assign results.valid    = vld_s5;
	assign results.y0_re    = y0_re_s5;
	assign results.y0_im    = y0_im_s5;
	assign results.y1_re    = y1_re_s5;
	assign results.y1_im    = y1_im_s5;
	assign results.y2_re    = y2_re_s5;
	assign results.y2_im    = y2_im_s5;
	assign results.last_out = last_s5;

endmodule

// ===== sim/butterfly_check.sv =====
// butterfly_check: watches both channels of radix3_twiddle_butterfly, predicts each
// result from the transferred butterfly and compares it field by field, in order.
// Depends on r3tb_pkg, r3tb_in_if and r3tb_out_if.
`timescale 1ns / 1ps

module butterfly_check
	import r3tb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	r3tb_in_if   samples,
	r3tb_out_if  results,
	output int   errors,
	output int   outstanding,
	output int   checked,
	output int   clipped
);

	localparam int     SW      = SAMPLE_WIDTH_DEF;
	localparam int     TW      = TWIDDLE_WIDTH_DEF;
	localparam int     OW      = SW + 3;
	localparam int     TW_FRAC = TW - 2;
	localparam longint TW_HALF = longint'(1) << (TW_FRAC - 1);
	localparam longint OUT_MAX = (longint'(1) << (OW - 1)) - 1;
	localparam longint OUT_MIN = -OUT_MAX - 1;
	localparam longint ROT_K   = longint'(SQRT3_HALF_Q16);
	localparam longint ROT_RND = longint'(ROT_HALF);

	typedef struct {
		logic signed [SW-1:0] x0_re, x0_im, x1_re, x1_im, x2_re, x2_im;
		logic signed [TW-1:0] w1_re, w1_im, w2_re, w2_im;
		logic                 last_in;
	} bfly_t;

	typedef struct {
		logic signed [OW-1:0] y0_re, y0_im, y1_re, y1_im, y2_re, y2_im;
		logic                 last_out;
	} spectrum_t;

	spectrum_t due_outputs[$];

	// one part of a twiddle product: exact sum, round half up, drop the fraction
	function automatic longint twiddle_round(input longint p, input longint q);
		return (p + q + TW_HALF) >>> TW_FRAC;
	endfunction

	// multiply by sqrt(3)/2 in Q0.16, round half up
	function automatic longint times_sqrt3_half(input longint v);
		return (v * ROT_K + ROT_RND) >>> ROT_SHIFT;
	endfunction

	// saturate into the widened output range, flag any clipping
	function automatic logic signed [OW-1:0] fit(input longint v, inout bit hit);
		if (v > OUT_MAX) begin
			v   = OUT_MAX;
			hit = 1'b1;
		end else if (v < OUT_MIN) begin
			v   = OUT_MIN;
			hit = 1'b1;
		end
		return v[OW-1:0];
	endfunction

	// X0, X1, X2 of one forward radix-3 butterfly
	function automatic spectrum_t radix3_outputs(input bfly_t b, output bit hit);
		longint    x0r, x0i, x1r, x1i, x2r, x2i, w1r, w1i, w2r, w2i;
		longint    v1r, v1i, v2r, v2i, sr, si, mr, mi, rr, ri;
		spectrum_t y;
		hit = 1'b0;
		x0r = longint'(b.x0_re);
		x0i = longint'(b.x0_im);
		x1r = longint'(b.x1_re);
		x1i = longint'(b.x1_im);
		x2r = longint'(b.x2_re);
		x2i = longint'(b.x2_im);
		w1r = longint'(b.w1_re);
		w1i = longint'(b.w1_im);
		w2r = longint'(b.w2_re);
		w2i = longint'(b.w2_im);
		v1r = twiddle_round(x1r * w1r, -(x1i * w1i));
		v1i = twiddle_round(x1r * w1i, x1i * w1r);
		v2r = twiddle_round(x2r * w2r, -(x2i * w2i));
		v2i = twiddle_round(x2r * w2i, x2i * w2r);
		sr  = v1r + v2r;
		si  = v1i + v2i;
		rr  = times_sqrt3_half(v2i - v1i);
		ri  = times_sqrt3_half(v2r - v1r);
		mr  = x0r - (sr >>> 1);
		mi  = x0i - (si >>> 1);
		y.y0_re    = fit(x0r + sr, hit);
		y.y0_im    = fit(x0i + si, hit);
		y.y1_re    = fit(mr - rr, hit);
		y.y1_im    = fit(mi + ri, hit);
		y.y2_re    = fit(mr + rr, hit);
		y.y2_im    = fit(mi - ri, hit);
		y.last_out = b.last_in;
		return y;
	endfunction

	function automatic int field_differs(input string name, input logic signed [OW-1:0] want,
			input logic signed [OW-1:0] got);
		if (got === want)
			return 0;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1;
	endfunction

	// compare result transfers first, then queue predictions for new butterflies
	always @(posedge clk) begin
		bfly_t     b;
		spectrum_t want;
		bit        hit;
		int        bad;
		bad = 0;
		if (arst_n) begin
			if (results.valid === 1'b1 && results.ready === 1'b1) begin
				if (due_outputs.size() == 0) begin
					$error("result transfer with no butterfly outstanding");
					bad = 1;
				end else begin
					want = due_outputs.pop_front();
					bad  = field_differs("y0_re", want.y0_re, results.y0_re)
						+ field_differs("y0_im", want.y0_im, results.y0_im)
						+ field_differs("y1_re", want.y1_re, results.y1_re)
						+ field_differs("y1_im", want.y1_im, results.y1_im)
						+ field_differs("y2_re", want.y2_re, results.y2_re)
						+ field_differs("y2_im", want.y2_im, results.y2_im)
						+ field_differs("last_out", OW'(want.last_out),
							OW'(results.last_out));
				end
				checked <= checked + 1;
			end
			if (samples.valid === 1'b1 && samples.ready === 1'b1) begin
				b.x0_re   = samples.x0_re;
				b.x0_im   = samples.x0_im;
				b.x1_re   = samples.x1_re;
				b.x1_im   = samples.x1_im;
				b.x2_re   = samples.x2_re;
				b.x2_im   = samples.x2_im;
				b.w1_re   = samples.w1_re;
				b.w1_im   = samples.w1_im;
				b.w2_re   = samples.w2_re;
				b.w2_im   = samples.w2_im;
				b.last_in = samples.last_in;
				due_outputs.push_back(radix3_outputs(b, hit));
				if (hit)
					clipped <= clipped + 1;
			end
			errors      <= errors + bad;
			outstanding <= due_outputs.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
// tb: drives radix3_twiddle_butterfly with directed corners and random butterflies,
// random idling on both channels and one long receiver hold-off; gives the verdict.
// Depends on r3tb_pkg, r3tb_in_if, r3tb_out_if, the block itself and butterfly_check.
`timescale 1ns / 1ps

module tb;
	import r3tb_pkg::*;

	localparam int SW           = SAMPLE_WIDTH_DEF;
	localparam int TW           = TWIDDLE_WIDTH_DEF;
	localparam int RANDOM_ITEMS = 1100;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 20;
	// receiver hold-off and quiet windows, in cycles after reset
	localparam int HOLD_FROM    = 400;
	localparam int HOLD_LEN     = 64;
	localparam int RX_CALM_FROM = 1100;
	localparam int RX_CALM_TO   = 1400;
	// sender quiet window, in random items
	localparam int TX_CALM_FROM = 500;
	localparam int TX_CALM_TO   = 700;

	typedef struct {
		logic signed [SW-1:0] x0_re, x0_im, x1_re, x1_im, x2_re, x2_im;
		logic signed [TW-1:0] w1_re, w1_im, w2_re, w2_im;
		logic                 last_in;
	} bfly_t;

	logic clk;
	logic arst_n;
	int   cycles;
	int   errors, outstanding, checked, clipped;
	int   sent, directed;

	r3tb_in_if  samples_if();
	r3tb_out_if results_if();

	radix3_twiddle_butterfly i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if)
	);

	butterfly_check i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples_if),
		.results     (results_if),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.clipped     (clipped)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("radix3_twiddle_butterfly regression: fail");
			$finish;
		end
	end

	function automatic bfly_t make_bfly(input int x0r, x0i, x1r, x1i, x2r, x2i,
			input int w1r, w1i, w2r, w2i, input bit last);
		bfly_t b;
		b.x0_re   = SW'(x0r);
		b.x0_im   = SW'(x0i);
		b.x1_re   = SW'(x1r);
		b.x1_im   = SW'(x1i);
		b.x2_re   = SW'(x2r);
		b.x2_im   = SW'(x2i);
		b.w1_re   = TW'(w1r);
		b.w1_im   = TW'(w1i);
		b.w2_re   = TW'(w2r);
		b.w2_im   = TW'(w2i);
		b.last_in = last;
		return b;
	endfunction

	// mostly full-range samples on in-range twiddles; some small samples,
	// unit-circle corners and raw 16-bit twiddles that can saturate
	function automatic bfly_t random_bfly();
		int kind;
		int s[6];
		int w[4];
		kind = $urandom_range(99);
		for (int i = 0; i < 6; i++)
			if (kind >= 65 && kind < 80)
				s[i] = int'($urandom_range(16)) - 8;
			else
				s[i] = int'($urandom_range(65535)) - 32768;
		for (int i = 0; i < 4; i++)
			if (kind < 80)
				w[i] = int'($urandom_range(32768)) - 16384;
			else if (kind < 93)
				case ($urandom_range(4))
					0:       w[i] = 16384;
					1:       w[i] = -16384;
					2:       w[i] = 0;
					3:       w[i] = 11585;
					default: w[i] = -11585;
				endcase
			else
				w[i] = int'($urandom_range(65535)) - 32768;
		return make_bfly(s[0], s[1], s[2], s[3], s[4], s[5], w[0], w[1], w[2], w[3],
			$urandom_range(7) == 0);
	endfunction

	task automatic put_fields(input bfly_t b);
		samples_if.x0_re   <= b.x0_re;
		samples_if.x0_im   <= b.x0_im;
		samples_if.x1_re   <= b.x1_re;
		samples_if.x1_im   <= b.x1_im;
		samples_if.x2_re   <= b.x2_re;
		samples_if.x2_im   <= b.x2_im;
		samples_if.w1_re   <= b.w1_re;
		samples_if.w1_im   <= b.w1_im;
		samples_if.w2_re   <= b.w2_re;
		samples_if.w2_im   <= b.w2_im;
		samples_if.last_in <= b.last_in;
	endtask

	// idle at random, then offer one butterfly and hold it until the transfer
	task automatic send_butterfly(input bfly_t b, input bit calm);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 16)
				gap++;
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid <= 1'b1;
		put_fields(b);
		@(posedge clk);
		while (samples_if.ready !== 1'b1)
			@(posedge clk);
		sent++;
	endtask

	// receiver: random stalls, one long hold-off, one stretch always ready
	initial begin
		int rx_cycle;
		rx_cycle = 0;
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_FROM + HOLD_LEN)
				results_if.ready <= 1'b0;
			else if (rx_cycle >= RX_CALM_FROM && rx_cycle < RX_CALM_TO)
				results_if.ready <= 1'b1;
			else
				results_if.ready <= ($urandom_range(99) >= 16);
		end
	end

	// sender: reset, directed corners, random butterflies, drain, verdict
	initial begin
		bfly_t corners[$];
		arst_n = 1'b0;
		samples_if.valid = 1'b0;
		put_fields(make_bfly(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		corners.push_back(make_bfly(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
		corners.push_back(make_bfly(32767, 32767, 32767, 32767, 32767, 32767,
			16384, 0, 16384, 0, 1'b1));
		corners.push_back(make_bfly(-32768, -32768, -32768, -32768, -32768, -32768,
			16384, 0, 16384, 0, 1'b0));
		corners.push_back(make_bfly(32767, 32767, 32767, 32767, 32767, 32767,
			-16384, 0, -16384, 0, 1'b1));
		corners.push_back(make_bfly(-32768, -32768, -32768, -32768, -32768, -32768,
			-16384, 0, -16384, 0, 1'b0));
		// twiddles of +j and -j
		corners.push_back(make_bfly(1000, -2000, 32767, -32768, -32768, 32767,
			0, 16384, 0, -16384, 1'b0));
		// most negative twiddle code, outside +-1.0
		corners.push_back(make_bfly(12345, -321, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768, 1'b1));
		// push outputs past both ends of the widened range
		corners.push_back(make_bfly(32767, 32767, -32768, 32767, -32768, 32767,
			-32768, -32768, -32768, -32768, 1'b0));
		corners.push_back(make_bfly(-32768, -32768, 32767, -32768, 32767, -32768,
			-32768, -32768, -32768, -32768, 1'b1));
		// product rounding ties: +0.5 rounds up, -0.5 rounds toward zero
		corners.push_back(make_bfly(0, 0, 1, 0, 1, 0, 8192, 0, 8192, 0, 1'b0));
		corners.push_back(make_bfly(0, 0, -1, 0, -1, 0, 8192, 0, 8192, 0, 1'b0));
		// odd sums through the halving shift
		corners.push_back(make_bfly(5, -5, 3, 0, 0, 0, 16384, 0, 0, 0, 1'b0));
		corners.push_back(make_bfly(0, 0, -3, 0, 0, 0, 16384, 0, 0, 0, 1'b1));
		// smallest differences through the sqrt(3)/2 rounding
		corners.push_back(make_bfly(0, 0, 0, 1, 0, 0, 16384, 0, 0, 0, 1'b0));
		corners.push_back(make_bfly(0, 0, 1, -1, 0, 0, 16384, 0, 0, 0, 1'b0));
		// alternating bit patterns
		corners.push_back(make_bfly(21845, -21846, 21845, -21846, -21846, 21845,
			5461, -5462, -5462, 5461, 1'b1));
		corners.push_back(make_bfly(-21846, 21845, -21846, 21845, 21845, -21846,
			16384, 16384, -16384, -16384, 1'b0));
		foreach (corners[i])
			send_butterfly(corners[i], 1'b0);
		directed = sent;

		for (int n = 0; n < RANDOM_ITEMS; n++)
			send_butterfly(random_bfly(), n >= TX_CALM_FROM && n < TX_CALM_TO);
		samples_if.valid <= 1'b0;

		// wait for the pipeline to empty, then watch for strays
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d butterflies: %0d directed corners, %0d random, %0d checked",
			sent, directed, sent - directed, checked);
		$display("%0d results saturated; receiver held off for %0d cycles once",
			clipped, HOLD_LEN);
		if (errors == 0 && outstanding == 0)
			$display("radix3_twiddle_butterfly regression: pass");
		else
			$display("radix3_twiddle_butterfly regression: fail");
		$finish;
	end

endmodule
